// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// same-cycle (overlapping) implication built on the clocked form
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== rtl/core/crcfr_pkg.sv =====
// types, constants and crc function for the framed command receiver
package crcfr_pkg;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [1:0] REG_START_MARK = 2'd0;
  localparam logic [1:0] REG_END_MARK   = 2'd1;
  localparam logic [1:0] REG_MAX_LEN    = 2'd2;

  localparam logic [7:0] START_MARK_RST = 8'd126;
  localparam logic [7:0] END_MARK_RST   = 8'd127;
  localparam logic [7:0] MAX_LEN_RST    = 8'd255;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } crcfr_in_t;

  typedef struct packed {
    logic       frame_ok;
    logic       frame_rejected;
    logic       receiving;
    logic       command_ready;
    logic [7:0] command_code;
    logic [7:0] module_address;
    logic [7:0] module_role;
  } crcfr_out_t;

  typedef struct packed {
    logic [7:0] start_mark;
    logic [7:0] end_mark;
    logic [7:0] max_frame_length;
  } crcfr_cfg_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/crcfr_engine.sv =====
// frame state, crc accumulation and header latching for one item per cycle on which fire is high
module crcfr_engine (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  crcfr_pkg::crcfr_in_t   item,
  input  crcfr_pkg::crcfr_cfg_t  cfg,
  output crcfr_pkg::crcfr_out_t  res
);
  import crcfr_pkg::*;

  logic        in_frame_r, in_frame_nxt;
  logic        valid_held_r, valid_held_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  dly_r [3];
  logic [7:0]  dly_nxt [3];
  logic [7:0]  hdr_r [3];
  logic [7:0]  hdr_nxt [3];
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  role_r, role_nxt;

  logic        ok, rej, clr;
  logic [8:0]  pos_inc;
  logic [15:0] crc_chk;
  logic [15:0] crc_upd;

  assign pos_inc = {1'b0, byte_count_r} + 9'd1;
  assign crc_upd = crc16_byte(crc_r, dly_r[2]);

  always_comb begin
    in_frame_nxt   = in_frame_r;
    valid_held_nxt = valid_held_r;
    byte_count_nxt = byte_count_r;
    crc_nxt        = crc_r;
    dly_nxt        = dly_r;
    hdr_nxt        = hdr_r;
    cmd_nxt        = cmd_r;
    addr_nxt       = addr_r;
    role_nxt       = role_r;
    ok             = 1'b0;
    rej            = 1'b0;
    clr            = 1'b0;
    crc_chk        = crc_r;

    if (item.kind == KIND_CLEAR) begin
      clr = 1'b1;
    end else if (!in_frame_r) begin
      if (item.rx_byte == cfg.start_mark) begin
        in_frame_nxt   = 1'b1;
        byte_count_nxt = 8'd1;
        crc_nxt        = 16'h0000;
        dly_nxt[0]     = item.rx_byte;
        dly_nxt[1]     = 8'h00;
        dly_nxt[2]     = 8'h00;
      end
    end else begin
      if (byte_count_r == 8'd1) hdr_nxt[0] = item.rx_byte;
      if (byte_count_r == 8'd2) hdr_nxt[1] = item.rx_byte;
      if (byte_count_r == 8'd3) hdr_nxt[2] = item.rx_byte;
      if (item.rx_byte == cfg.end_mark) begin
        in_frame_nxt = 1'b0;
        if (byte_count_r < 8'd3) begin
          rej = 1'b1;
        end else begin
          if (byte_count_r >= 8'd4) crc_chk = crc_upd;
          ok  = (crc_chk[7:0] == dly_r[1]) && (crc_chk[15:8] == dly_r[0]);
          rej = !ok;
        end
        valid_held_nxt = ok;
        if (ok) begin
          role_nxt = hdr_nxt[0];
          addr_nxt = hdr_nxt[1];
          cmd_nxt  = hdr_nxt[2];
        end
      end else begin
        if (byte_count_r >= 8'd4) crc_nxt = crc_upd;
        dly_nxt[2] = dly_r[1];
        dly_nxt[1] = dly_r[0];
        dly_nxt[0] = item.rx_byte;
      end
      byte_count_nxt = pos_inc[7:0];
      if (pos_inc >= {1'b0, cfg.max_frame_length}) clr = 1'b1;
    end

    if (clr) begin
      in_frame_nxt   = 1'b0;
      valid_held_nxt = 1'b0;
      byte_count_nxt = 8'd0;
      crc_nxt        = 16'h0000;
      for (int i = 0; i < 3; i++) begin
        dly_nxt[i] = 8'h00;
        hdr_nxt[i] = 8'h00;
      end
      cmd_nxt  = 8'h00;
      addr_nxt = 8'h00;
      role_nxt = 8'h00;
    end
  end

  always_comb begin
    res.frame_ok       = ok;
    res.frame_rejected = rej;
    res.receiving      = in_frame_nxt;
    res.command_ready  = valid_held_nxt;
    res.command_code   = cmd_nxt;
    res.module_address = addr_nxt;
    res.module_role    = role_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      valid_held_r <= 1'b0;
      byte_count_r <= 8'd0;
      crc_r        <= 16'h0000;
      for (int i = 0; i < 3; i++) begin
        dly_r[i] <= 8'h00;
        hdr_r[i] <= 8'h00;
      end
      cmd_r  <= 8'h00;
      addr_r <= 8'h00;
      role_r <= 8'h00;
    end else if (fire) begin
      in_frame_r   <= in_frame_nxt;
      valid_held_r <= valid_held_nxt;
      byte_count_r <= byte_count_nxt;
      crc_r        <= crc_nxt;
      dly_r        <= dly_nxt;
      hdr_r        <= hdr_nxt;
      cmd_r        <= cmd_nxt;
      addr_r       <= addr_nxt;
      role_r       <= role_nxt;
    end
  end

endmodule

// ===== rtl/core/crc16_framed_command_receiver_core.sv =====
// top level: input register, frame engine, result register and config registers
// path: input register, then engine, then result register, which raises out_valid
// throughput: one item per cycle unless stalled, via the combinational byte-wide crc update
// a stalled result lets one more item wait in the input register, then in_stall rises
// reset: synchronous active-low rst_n clears frame state and latches, presets config
module crc16_framed_command_receiver_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  crcfr_pkg::crcfr_in_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output crcfr_pkg::crcfr_out_t out_item,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_wdata
);
  import crcfr_pkg::*;

  logic       in_vld_r;
  crcfr_in_t  in_item_r;
  logic       out_vld_r;
  crcfr_out_t out_item_r;
  crcfr_cfg_t cfg_r;
  crcfr_out_t res;
  logic       advance;

  assign advance   = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !advance;
  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  crcfr_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (in_item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_mark       <= START_MARK_RST;
      cfg_r.end_mark         <= END_MARK_RST;
      cfg_r.max_frame_length <= MAX_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_MARK: cfg_r.start_mark       <= cfg_wdata;
        REG_END_MARK:   cfg_r.end_mark         <= cfg_wdata;
        REG_MAX_LEN:    cfg_r.max_frame_length <= cfg_wdata;
        default:        cfg_r <= cfg_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/crcfr_checker.sv =====
// port-level checker for the framed command receiver, with its bind
`include "assert_macros.svh"

module crcfr_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input crcfr_pkg::crcfr_out_t out_item
);
  import crcfr_pkg::*;

  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_item), "stalled item changed")
  `ASSERT_IMPLIES(a_verdict_excl, clk, rst_n, out_valid, !(out_item.frame_ok && out_item.frame_rejected), "ok and rejected together")
  `ASSERT_IMPLIES(a_ok_closes, clk, rst_n, out_valid && out_item.frame_ok, !out_item.receiving, "frame ok while still receiving")
  `ASSERT_IMPLIES(a_rej_drops, clk, rst_n, out_valid && out_item.frame_rejected, !out_item.command_ready && !out_item.receiving, "rejected frame left command ready")

endmodule

bind crc16_framed_command_receiver_core crcfr_checker u_crcfr_checker (.*);

// ===== verif/crc16_framed_command_receiver_core_tb.sv =====
// self-checking testbench for the crc16 framed command receiver core
module crc16_framed_command_receiver_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crcfr_pkg::*;

  localparam int PHASE_ITEMS = 200;
  localparam int QUIET_LIMIT = 3000;
  localparam int LATENCY_PAD = 6;
  localparam int LONG_HOLD   = 150;
  localparam int HOLD_AT     = 500;
  localparam int N_PLAN      = 6;
  localparam int LONG_PHASE  = 5;

  typedef enum logic [1:0] {SRC_LIT, SRC_DATA, SRC_CRC_LO, SRC_CRC_HI} byte_src_e;

  typedef struct packed {
    logic       kind;
    byte_src_e  src;
    logic [7:0] val;
    logic       typed;
    crcfr_out_t want;
  } script_row_t;

  typedef struct packed {
    crcfr_in_t  item;
    logic       typed;
    crcfr_out_t want;
  } feed_entry_t;

  localparam crcfr_out_t OUT_IDLE    = '0;
  localparam crcfr_out_t OUT_OPEN    = {4'b0010, 24'h0};
  localparam crcfr_out_t OUT_SHORT   = {4'b0100, 24'h0};
  localparam crcfr_out_t OUT_TINY_OK = {4'b1001, 8'h7F, 8'h00, 8'h00};

  localparam script_row_t SCRIPT [26] = '{
    '{KIND_BYTE,  SRC_LIT,    8'h00, 1'b1, OUT_IDLE},
    '{KIND_BYTE,  SRC_LIT,    8'hFF, 1'b1, OUT_IDLE},
    '{KIND_CLEAR, SRC_LIT,    8'hFF, 1'b1, OUT_IDLE},
    '{KIND_BYTE,  SRC_LIT,    8'h7E, 1'b1, OUT_OPEN},
    '{KIND_BYTE,  SRC_LIT,    8'h7F, 1'b1, OUT_SHORT},
    '{KIND_BYTE,  SRC_LIT,    8'h7E, 1'b1, OUT_OPEN},
    '{KIND_BYTE,  SRC_LIT,    8'h00, 1'b1, OUT_OPEN},
    '{KIND_BYTE,  SRC_LIT,    8'h00, 1'b1, OUT_OPEN},
    '{KIND_BYTE,  SRC_LIT,    8'h7F, 1'b1, OUT_TINY_OK},
    '{KIND_BYTE,  SRC_LIT,    8'h7E, 1'b0, OUT_IDLE},
    '{KIND_BYTE,  SRC_DATA,   8'hFF, 1'b0, OUT_IDLE},
    '{KIND_BYTE,  SRC_DATA,   8'hFF, 1'b0, OUT_IDLE},
    '{KIND_BYTE,  SRC_DATA,   8'hFF, 1'b0, OUT_IDLE},
    '{KIND_BYTE,  SRC_CRC_LO, 8'h00, 1'b0, OUT_IDLE},
    '{KIND_BYTE,  SRC_CRC_HI, 8'h00, 1'b0, OUT_IDLE},
    '{KIND_BYTE,  SRC_LIT,    8'h7F, 1'b0, OUT_IDLE},
    '{KIND_BYTE,  SRC_LIT,    8'h7E, 1'b0, OUT_IDLE},
    '{KIND_BYTE,  SRC_DATA,   8'h80, 1'b0, OUT_IDLE},
    '{KIND_BYTE,  SRC_LIT,    8'h7F, 1'b0, OUT_IDLE},
    '{KIND_BYTE,  SRC_LIT,    8'h7E, 1'b0, OUT_IDLE},
    '{KIND_BYTE,  SRC_DATA,   8'h01, 1'b0, OUT_IDLE},
    '{KIND_BYTE,  SRC_CRC_LO, 8'h00, 1'b0, OUT_IDLE},
    '{KIND_BYTE,  SRC_LIT,    8'h00, 1'b0, OUT_IDLE},
    '{KIND_BYTE,  SRC_LIT,    8'h7F, 1'b0, OUT_IDLE},
    '{KIND_BYTE,  SRC_LIT,    8'h7E, 1'b0, OUT_IDLE},
    '{KIND_CLEAR, SRC_LIT,    8'h00, 1'b1, OUT_IDLE}
  };

  localparam crcfr_cfg_t PLAN [N_PLAN] = '{
    '{8'h00, 8'hFF, 8'd4},
    '{8'hFF, 8'h00, 8'd255},
    '{8'hA5, 8'h5A, 8'd12},
    '{8'h55, 8'h55, 8'd40},
    '{8'h7E, 8'h7F, 8'd5},
    '{8'h7E, 8'h7F, 8'd255}
  };

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  crcfr_in_t  in_item;
  logic       out_valid;
  logic       out_stall;
  crcfr_out_t out_item;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  crc16_framed_command_receiver_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver state mirror
  crcfr_cfg_t  mark_cfg;
  logic        frame_open;
  logic        cmd_valid;
  logic [7:0]  held_count;
  logic [15:0] crc_run;
  logic [7:0]  recent [3];
  logic [7:0]  hdr [3];
  logic [7:0]  cmd_q;
  logic [7:0]  addr_q;
  logic [7:0]  role_q;

  feed_entry_t byte_feed_q [$];
  crcfr_out_t  status_due_q [$];
  int outstanding = 0;
  int queued = 0;
  int items_sent = 0;
  int clears_sent = 0;
  int results_seen = 0;
  int good_frames = 0;
  int bad_frames = 0;
  int mismatches = 0;
  int strays = 0;
  int quiet_cycles = 0;

  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb = acc[15] ^ d[k];
      acc = {acc[14:0], 1'b0};
      if (fb) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

  function automatic void wipe_receiver();
    frame_open = 1'b0;
    cmd_valid  = 1'b0;
    held_count = '0;
    crc_run    = '0;
    for (int i = 0; i < 3; i++) begin
      recent[i] = '0;
      hdr[i]    = '0;
    end
    cmd_q  = '0;
    addr_q = '0;
    role_q = '0;
  endfunction

  function automatic crcfr_out_t rx_status_after(input crcfr_in_t it);
    crcfr_out_t  r;
    logic [15:0] sum;
    int          pos;
    r = '0;
    if (it.kind == KIND_CLEAR) begin
      wipe_receiver();
    end else if (!frame_open) begin
      if (it.rx_byte == mark_cfg.start_mark) begin
        frame_open = 1'b1;
        held_count = 8'd1;
        crc_run    = '0;
        recent[0]  = it.rx_byte;
        recent[1]  = '0;
        recent[2]  = '0;
      end
    end else begin
      pos = int'(held_count);
      if (pos >= 1 && pos <= 3) hdr[pos-1] = it.rx_byte;
      if (it.rx_byte == mark_cfg.end_mark) begin
        frame_open = 1'b0;
        if (pos < 3) begin
          r.frame_rejected = 1'b1;
        end else begin
          sum = crc_run;
          if (pos >= 4) sum = crc16_step(sum, recent[2]);
          r.frame_ok = (sum[7:0] == recent[1]) && (sum[15:8] == recent[0]);
          r.frame_rejected = !r.frame_ok;
        end
        cmd_valid = r.frame_ok;
        if (r.frame_ok) begin
          role_q = hdr[0];
          addr_q = hdr[1];
          cmd_q  = hdr[2];
        end
      end else begin
        if (pos >= 4) crc_run = crc16_step(crc_run, recent[2]);
        recent[2] = recent[1];
        recent[1] = recent[0];
        recent[0] = it.rx_byte;
      end
      held_count = held_count + 8'd1;
      if (pos + 1 >= mark_cfg.max_frame_length) wipe_receiver();
    end
    r.receiving      = frame_open;
    r.command_ready  = cmd_valid;
    r.command_code   = cmd_q;
    r.module_address = addr_q;
    r.module_role    = role_q;
    return r;
  endfunction

  task automatic queue_item(input logic kind, input logic [7:0] b);
    feed_entry_t e;
    e = '0;
    e.item.kind    = kind;
    e.item.rx_byte = b;
    byte_feed_q = {byte_feed_q, e};
    outstanding++;
    queued++;
  endtask

  function automatic logic [7:0] data_byte();
    logic [7:0] d;
    if ($urandom_range(0, 6) == 0 && mark_cfg.start_mark != mark_cfg.end_mark)
      return mark_cfg.start_mark;
    do d = 8'($urandom_range(0, 255)); while (d == mark_cfg.end_mark);
    return d;
  endfunction

  task automatic queue_frame(input int k, input bit corrupt);
    logic [15:0] sum;
    logic [15:0] flip;
    logic [7:0]  d;
    sum = '0;
    queue_item(KIND_BYTE, mark_cfg.start_mark);
    for (int i = 0; i < k; i++) begin
      d = data_byte();
      queue_item(KIND_BYTE, d);
      sum = crc16_step(sum, d);
    end
    if (corrupt) begin
      flip = 16'($urandom_range(1, 65535));
      sum = sum ^ flip;
    end
    queue_item(KIND_BYTE, sum[7:0]);
    queue_item(KIND_BYTE, sum[15:8]);
    queue_item(KIND_BYTE, mark_cfg.end_mark);
  endtask

  task automatic queue_traffic(input int budget);
    int first;
    int pick;
    int k;
    int keep;
    first = queued;
    while (queued - first < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
        queue_frame(k, $urandom_range(0, 6) == 0);
      end else if (pick < 74) begin
        // short or cut-off frame
        queue_item(KIND_BYTE, mark_cfg.start_mark);
        repeat ($urandom_range(0, 2)) queue_item(KIND_BYTE, data_byte());
        if ($urandom_range(0, 1) == 1) queue_item(KIND_BYTE, mark_cfg.end_mark);
        else queue_item(KIND_CLEAR, 8'($urandom_range(0, 255)));
      end else if (pick < 86) begin
        // line noise, mostly ignored while idle
        keep = queued;
        repeat ($urandom_range(1, 4)) queue_item(KIND_BYTE, 8'($urandom_range(0, 255)));
        queued = keep;
      end else if (pick < 93) begin
        queue_item(KIND_CLEAR, 8'($urandom_range(0, 255)));
      end else begin
        // abandoned frame, the next frame start lands inside it
        queue_item(KIND_BYTE, mark_cfg.start_mark);
        repeat ($urandom_range(1, 6)) queue_item(KIND_BYTE, data_byte());
      end
    end
  endtask

  task automatic settle();
    do @(posedge clk); while (outstanding != 0 || status_due_q.size() != 0);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  task automatic load_marks(input crcfr_cfg_t marks);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_MARK;
    cfg_wdata <= marks.start_mark;
    @(posedge clk);
    cfg_index <= REG_END_MARK;
    cfg_wdata <= marks.end_mark;
    @(posedge clk);
    cfg_index <= REG_MAX_LEN;
    cfg_wdata <= marks.max_frame_length;
    @(posedge clk);
    cfg_we <= 1'b0;
    mark_cfg = marks;
  endtask

  // stimulus and phase control
  initial begin
    script_row_t row;
    feed_entry_t ent;
    logic [15:0] dir_crc;
    logic [15:0] crc_hold;
    logic [7:0]  val;
    int          fails;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_START_MARK;
    cfg_wdata <= '0;
    mark_cfg = '{START_MARK_RST, END_MARK_RST, MAX_LEN_RST};
    wipe_receiver();
    dir_crc  = '0;
    crc_hold = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (SCRIPT[i]) begin
      row = SCRIPT[i];
      case (row.src)
        SRC_DATA: begin
          val = row.val;
          dir_crc = crc16_step(dir_crc, val);
        end
        SRC_CRC_LO: begin
          crc_hold = dir_crc;
          dir_crc = '0;
          val = crc_hold[7:0];
        end
        SRC_CRC_HI: val = crc_hold[15:8];
        default: val = row.val;
      endcase
      ent.item.kind    = row.kind;
      ent.item.rx_byte = val;
      ent.typed        = row.typed;
      ent.want         = row.want;
      byte_feed_q = {byte_feed_q, ent};
      outstanding++;
      queued++;
    end
    settle();

    for (int p = 0; p < N_PLAN; p++) begin
      load_marks(PLAN[p]);
      if (p == LONG_PHASE) begin
        // one frame that closes exactly at the length limit, one that runs past it
        queue_frame(251, 1'b0);
        queue_frame(262, 1'b0);
      end
      queue_traffic(PHASE_ITEMS);
      settle();
    end

    fails = mismatches + strays + status_due_q.size();
    $display("tb: %0d items over %0d mark settings, %0d results checked",
             items_sent, N_PLAN + 1, results_seen);
    $display("tb: %0d good frames, %0d rejected frames, %0d clears",
             good_frames, bad_frames, clears_sent);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // input side: drives items with random gaps, predicts on accept
  initial begin
    feed_entry_t cur;
    crcfr_out_t  predicted;
    int          gap_left;
    bit          calm;
    logic        offer;
    in_valid <= 1'b0;
    in_item  <= '0;
    cur = '0;
    gap_left = 0;
    calm = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      offer = in_valid;
      if (in_valid && !in_stall) begin
        predicted = rx_status_after(cur.item);
        status_due_q = {status_due_q, (cur.typed ? cur.want : predicted)};
        if (cur.item.kind == KIND_CLEAR) clears_sent++;
        outstanding--;
        items_sent++;
        if (items_sent % 50 == 0) calm = ($urandom_range(0, 3) == 0);
        gap_left = calm ? 0 : $urandom_range(0, 17);
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (byte_feed_q.size() != 0) begin
          cur = byte_feed_q.pop_front();
          in_item <= cur.item;
          offer = 1'b1;
        end
      end
      in_valid <= offer;
      @(posedge clk);
    end
  end

  // result side: random stall, one long hold-off, compares against the oldest prediction
  initial begin
    crcfr_out_t want;
    int         hold_left;
    bit         calm;
    out_stall <= 1'b0;
    hold_left = 0;
    calm = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_item.frame_ok) good_frames++;
        if (out_item.frame_rejected) bad_frames++;
        if (status_due_q.size() == 0) begin
          strays++;
          if (strays + mismatches <= 10)
            $display("tb: unexpected result %0d: %p", results_seen, out_item);
        end else begin
          want = status_due_q.pop_front();
          if (out_item.frame_ok !== want.frame_ok ||
              out_item.frame_rejected !== want.frame_rejected ||
              out_item.receiving !== want.receiving ||
              out_item.command_ready !== want.command_ready ||
              out_item.command_code !== want.command_code ||
              out_item.module_address !== want.module_address ||
              out_item.module_role !== want.module_role) begin
            mismatches++;
            if (strays + mismatches <= 10) begin
              $display("tb: result %0d expected ok=%b rej=%b rx=%b rdy=%b cmd=%h addr=%h role=%h",
                       results_seen, want.frame_ok, want.frame_rejected, want.receiving,
                       want.command_ready, want.command_code, want.module_address,
                       want.module_role);
              $display("tb: result %0d actual   ok=%b rej=%b rx=%b rdy=%b cmd=%h addr=%h role=%h",
                       results_seen, out_item.frame_ok, out_item.frame_rejected,
                       out_item.receiving, out_item.command_ready, out_item.command_code,
                       out_item.module_address, out_item.module_role);
            end
          end
        end
        if (results_seen % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        if (results_seen == HOLD_AT) hold_left = LONG_HOLD;
        else hold_left = calm ? 0 : $urandom_range(0, 17);
      end
      out_stall <= (hold_left != 0);
      if (hold_left != 0) hold_left--;
      @(posedge clk);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/crcfr_pkg.sv
rtl/core/crcfr_engine.sv
rtl/core/crc16_framed_command_receiver_core.sv
rtl/core/crcfr_checker.sv
verif/crc16_framed_command_receiver_core_tb.sv
